### design/u2d_pkg.sv
// Shared constants, types and helpers for the unsigned to decimal ASCII converter.
// No dependencies.
`default_nettype none

package u2d_pkg;

  localparam int DEF_VALUE_BITS = 32;
  localparam int DIGIT_BITS     = 6;
  localparam int BITS_PER_STEP  = 4;
  localparam int NIBBLE_BITS    = 4;

  localparam logic [DIGIT_BITS-1:0] ASCII_ZERO = 6'h30;

  // Decimal digits needed for the largest value of the given width.
  function automatic int digit_count(input int bits);
    return (bits * 1233) / 4096 + 1;
  endfunction

  function automatic int step_count(input int bits);
    return (bits + BITS_PER_STEP - 1) / BITS_PER_STEP;
  endfunction

  typedef struct packed {
    logic load;
    logic shift;
    logic start_emit;
    logic next_digit;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

endpackage

`default_nettype wire

### design/u2d_value_if.sv
// Input channel carrying one unsigned number per item.
// No dependencies.
`default_nettype none

interface u2d_value_if #(
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

### design/u2d_digit_if.sv
// Output channel carrying one ASCII digit per item with a last flag.
// No dependencies.
`default_nettype none

interface u2d_digit_if;
  logic       valid;
  logic       ready;
  logic [5:0] digit_char;
  logic       last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

`default_nettype wire

### design/unsigned_to_decimal_ascii.sv
// Unsigned binary to decimal ASCII converter, top level.
// The first digit is valid once the shift and add-3 converter, which takes four bits
// a cycle, has run over the whole value and the leading digit has been found.
// One number is in flight at a time: a new item is accepted only after the last
// digit of the previous one has been taken.
// Reset: synchronous, returns the controller to idle; nothing is kept between items.
`default_nettype none

module unsigned_to_decimal_ascii #(
  parameter int VALUE_BITS = u2d_pkg::DEF_VALUE_BITS
) (
  input wire logic     clk,
  input wire logic     rst,
  u2d_value_if.sink    number,
  u2d_digit_if.source  digits
);
  import u2d_pkg::*;

  cmd_t    cmd;
  status_t status;

  u2d_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .out_valid (digits.valid),
    .out_ready (digits.ready),
    .cmd       (cmd),
    .status    (status)
  );

  u2d_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk        (clk),
    .value      (number.value),
    .cmd        (cmd),
    .status     (status),
    .digit_char (digits.digit_char)
  );

  assign digits.last_digit = status.last;

endmodule

`default_nettype wire

### design/u2d_ctrl.sv
// Controller: sequences load, conversion steps, leading digit search and emission.
// Depends on u2d_pkg.
`default_nettype none

module u2d_ctrl #(
  parameter int VALUE_BITS = u2d_pkg::DEF_VALUE_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output u2d_pkg::cmd_t         cmd,
  input  wire u2d_pkg::status_t status
);
  import u2d_pkg::*;

  localparam int STEPS  = step_count(VALUE_BITS);
  localparam int STEP_W = $clog2(STEPS + 1);

  typedef enum logic [3:0] {
    IDLE = 4'b0001,
    CONV = 4'b0010,
    FIND = 4'b0100,
    EMIT = 4'b1000
  } state_t;

  state_t             state, state_next;
  logic [STEP_W-1:0]  step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          step_next  = STEP_W'(STEPS - 1);
          state_next = CONV;
        end
      end
      CONV: begin
        cmd.shift = 1'b1;
        if (step == '0) begin
          state_next = FIND;
        end else begin
          step_next = step - 1'b1;
        end
      end
      FIND: begin
        cmd.start_emit = 1'b1;
        state_next     = EMIT;
      end
      EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.last) begin
            state_next = IDLE;
          end else begin
            cmd.next_digit = 1'b1;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/u2d_datapath.sv
// Datapath: shift and add-3 binary to BCD conversion, four bits per cycle,
// and a digit pointer that walks the BCD word from the leading digit down.
// Depends on u2d_pkg.
`default_nettype none

module u2d_datapath #(
  parameter int VALUE_BITS = u2d_pkg::DEF_VALUE_BITS
) (
  input  wire logic                              clk,
  input  wire logic [VALUE_BITS-1:0]             value,
  input  wire u2d_pkg::cmd_t                     cmd,
  output u2d_pkg::status_t                       status,
  output logic [u2d_pkg::DIGIT_BITS-1:0]         digit_char
);
  import u2d_pkg::*;

  localparam int STEPS  = step_count(VALUE_BITS);
  localparam int PAD    = STEPS * BITS_PER_STEP;
  localparam int DIGITS = digit_count(VALUE_BITS);
  localparam int BCD_W  = DIGITS * NIBBLE_BITS;
  localparam int IDX_W  = $clog2(DIGITS);

  logic [PAD-1:0]   shreg;
  logic [BCD_W-1:0] bcd;
  logic [IDX_W-1:0] idx;

  logic [PAD-1:0]   shreg_next;
  logic [BCD_W-1:0] bcd_next;
  logic [IDX_W-1:0] lead;
  logic [NIBBLE_BITS-1:0] nibble;

  always_comb begin
    bcd_next   = bcd;
    shreg_next = shreg;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      for (int j = 0; j < DIGITS; j++) begin
        if (bcd_next[j*NIBBLE_BITS +: NIBBLE_BITS] >= 4'd5) begin
          bcd_next[j*NIBBLE_BITS +: NIBBLE_BITS] =
            bcd_next[j*NIBBLE_BITS +: NIBBLE_BITS] + 4'd3;
        end
      end
      bcd_next   = {bcd_next[BCD_W-2:0], shreg_next[PAD-1]};
      shreg_next = {shreg_next[PAD-2:0], 1'b0};
    end
  end

  always_comb begin
    lead = '0;
    for (int j = 0; j < DIGITS; j++) begin
      if (bcd[j*NIBBLE_BITS +: NIBBLE_BITS] != '0) begin
        lead = IDX_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shreg <= PAD'(value);
      bcd   <= '0;
    end else if (cmd.shift) begin
      shreg <= shreg_next;
      bcd   <= bcd_next;
    end
    if (cmd.start_emit) begin
      idx <= lead;
    end else if (cmd.next_digit) begin
      idx <= idx - 1'b1;
    end
  end

  assign nibble      = bcd[{idx, 2'b00} +: NIBBLE_BITS];
  assign digit_char  = ASCII_ZERO | DIGIT_BITS'(nibble);
  assign status.last = (idx == '0);

endmodule

`default_nettype wire
